// ===== src/ird_pkg.sv =====
`default_nettype none

package ird_pkg;

  // Field and table geometry
  localparam int ADC_BITS   = 12;
  localparam int FRAC_BITS  = 8;
  localparam int MAX_POINTS = 16;
  localparam int NUM_TABLES = 3;
  localparam int SEL_W      = 2;
  localparam int INCH_W     = 5;
  localparam int DIST_W     = INCH_W + FRAC_BITS;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int TAB_DEPTH  = NUM_TABLES * MAX_POINTS;
  localparam int ADDR_W     = $clog2(TAB_DEPTH);
  localparam int CAL_W      = INCH_W + ADC_BITS;
  localparam int NUM_W      = ADC_BITS + DIST_W;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  typedef logic [ADC_BITS-1:0] adc_t;
  typedef logic [SEL_W-1:0]    sel_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef enum logic [1:0] {
    TBL_LEFT   = 2'd0,
    TBL_CENTER = 2'd1,
    TBL_RIGHT  = 2'd2
  } tbl_e;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [INCH_W-1:0] inches;
    adc_t              code;
  } cal_point_t;

  // Divider request: multiplier operands and divisor
  typedef struct packed {
    logic              start;
    adc_t              mdiff;
    logic [INCH_W-1:0] span;
    adc_t              den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic  valid;
    dist_t distance;
    adc_t  median;
  } res_t;

  // Calibration tables, unused tail entries zero
  localparam cal_point_t CAL_LEFT [MAX_POINTS] = '{
    '{5'd0, 12'd205},   '{5'd1, 12'd1533},  '{5'd2, 12'd2397},  '{5'd3, 12'd3025},
    '{5'd4, 12'd3353},  '{5'd5, 12'd3409},  '{5'd6, 12'd3537},  '{5'd7, 12'd3580},
    '{5'd8, 12'd3600},  '{5'd9, 12'd3640},  '{5'd10, 12'd3660}, '{5'd18, 12'd3817},
    '{5'd0, 12'd0},     '{5'd0, 12'd0},     '{5'd0, 12'd0},     '{5'd0, 12'd0}
  };

  localparam cal_point_t CAL_CENTER [MAX_POINTS] = '{
    '{5'd0, 12'd128},   '{5'd1, 12'd243},   '{5'd2, 12'd273},   '{5'd3, 12'd349},
    '{5'd4, 12'd890},   '{5'd5, 12'd1457},  '{5'd6, 12'd1900},  '{5'd7, 12'd2265},
    '{5'd8, 12'd2513},  '{5'd9, 12'd2745},  '{5'd10, 12'd2890}, '{5'd11, 12'd3000},
    '{5'd12, 12'd3125}, '{5'd13, 12'd3200}, '{5'd14, 12'd3265}, '{5'd18, 12'd3717}
  };

  localparam cal_point_t CAL_RIGHT [MAX_POINTS] = '{
    '{5'd0, 12'd190},   '{5'd1, 12'd555},   '{5'd2, 12'd2197},  '{5'd3, 12'd2937},
    '{5'd4, 12'd3269},  '{5'd5, 12'd3473},  '{5'd6, 12'd3545},  '{5'd7, 12'd3609},
    '{5'd8, 12'd3656},  '{5'd9, 12'd3700},  '{5'd10, 12'd3720}, '{5'd18, 12'd3792},
    '{5'd0, 12'd0},     '{5'd0, 12'd0},     '{5'd0, 12'd0},     '{5'd0, 12'd0}
  };

  function automatic cal_point_t cal_rom(tbl_e tbl, idx_t idx);
    cal_point_t pt;
    unique case (tbl)
      TBL_LEFT:   pt = CAL_LEFT[idx];
      TBL_CENTER: pt = CAL_CENTER[idx];
      TBL_RIGHT:  pt = CAL_RIGHT[idx];
      default:    pt = '0;
    endcase
    return pt;
  endfunction

  // Index of the last point in each table
  function automatic idx_t tbl_last(tbl_e tbl);
    idx_t last;
    unique case (tbl)
      TBL_LEFT:   last = idx_t'(11);
      TBL_CENTER: last = idx_t'(MAX_POINTS - 1);
      TBL_RIGHT:  last = idx_t'(11);
      default:    last = idx_t'(MAX_POINTS - 1);
    endcase
    return last;
  endfunction

  function automatic tbl_e sel_to_tbl(sel_t sel);
    tbl_e tbl;
    unique case (sel)
      2'd0:    tbl = TBL_LEFT;
      2'd2:    tbl = TBL_RIGHT;
      default: tbl = TBL_CENTER;
    endcase
    return tbl;
  endfunction

  function automatic addr_t tbl_addr(tbl_e tbl, idx_t idx);
    return addr_t'(addr_t'(tbl) * addr_t'(MAX_POINTS) + addr_t'(idx));
  endfunction

  function automatic adc_t med3(adc_t a, adc_t b, adc_t c);
    adc_t lo;
    adc_t hi;
    adc_t hc;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hc = (hi < c) ? hi : c;
    return (lo > hc) ? lo : hc;
  endfunction

endpackage

`default_nettype wire

// ===== src/ird_if.sv =====
`default_nettype none

interface ird_in_if;
  import ird_pkg::*;

  logic valid;
  logic ready;
  sel_t sensor_sel;
  adc_t sample_a;
  adc_t sample_b;
  adc_t sample_c;

  modport source (output valid, sensor_sel, sample_a, sample_b, sample_c, input ready);
  modport sink   (input valid, sensor_sel, sample_a, sample_b, sample_c, output ready);
endinterface

interface ird_out_if;
  import ird_pkg::*;

  logic  valid;
  logic  ready;
  dist_t distance_q8;
  adc_t  median_raw;

  modport source (output valid, distance_q8, median_raw, input ready);
  modport sink   (input valid, distance_q8, median_raw, output ready);
endinterface

`default_nettype wire

// ===== src/ird_ram.sv =====
`default_nettype none

module ird_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/ird_div.sv =====
`default_nettype none

module ird_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ird_pkg::div_req_t  req_i,
  output ird_pkg::div_rsp_t       rsp_o
);
  import ird_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, num_d;
  adc_t             rem_q, rem_d;
  adc_t             den_q;
  logic [ADC_BITS:0] trial;
  logic             ge;

  // One restoring step: shift in a numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? adc_t'(trial - {1'b0, den_q}) : trial[ADC_BITS-1:0];
    num_d = {num_q[NUM_W-2:0], ge};
  end

  // Control: iteration count and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: product on start, then one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= NUM_W'(req_i.mdiff) * NUM_W'({req_i.span, {FRAC_BITS{1'b0}}});
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

`default_nettype wire

// ===== src/ird_ctrl.sv =====
`default_nettype none

module ird_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ird_pkg::tbl_e     tbl_i,
  input  wire ird_pkg::adc_t     median_i,
  output logic                   in_ready_o,
  input  wire logic              out_free_i,
  output ird_pkg::res_t          res_o,
  output ird_pkg::div_req_t      div_req_o,
  input  wire ird_pkg::div_rsp_t div_rsp_i
);
  import ird_pkg::*;

  ctrl_state_e state_q, state_d;
  addr_t       fill_q, fill_d;
  idx_t        idx_q, idx_d;
  tbl_e        tbl_q, tbl_d;
  adc_t        median_q, median_d;
  cal_point_t  prev_q, prev_d;
  logic [INCH_W-1:0] base_q, base_d;
  dist_t       dist_q, dist_d;

  logic        ram_we;
  cal_point_t  ram_wdata;
  addr_t       ram_raddr;
  logic [CAL_W-1:0] ram_rdata;
  cal_point_t  rd;
  tbl_e        fill_tbl;
  idx_t        fill_idx;

  // Table store, loaded from the constant tables after reset
  ird_ram #(
    .WIDTH (CAL_W),
    .DEPTH (TAB_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fill_tbl  = tbl_e'(SEL_W'(fill_q / MAX_POINTS));
  assign fill_idx  = idx_t'(fill_q % MAX_POINTS);
  assign ram_wdata = cal_rom(fill_tbl, fill_idx);
  assign rd        = cal_point_t'(ram_rdata);

  // Next state: fill, accept, walk breakpoints, divide, hand off
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    tbl_d     = tbl_q;
    median_d  = median_q;
    prev_d    = prev_q;
    base_d    = base_q;
    dist_d    = dist_q;
    ram_we    = 1'b0;
    ram_raddr = tbl_addr(tbl_q, idx_q);
    in_ready_o = 1'b0;
    div_req_o = '0;
    res_o.valid    = 1'b0;
    res_o.distance = dist_q;
    res_o.median   = median_q;

    unique case (state_q)
      ST_FILL: begin
        ram_we = 1'b1;
        fill_d = fill_q + addr_t'(1);
        if (fill_q == addr_t'(TAB_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = tbl_addr(tbl_i, '0);
        if (in_valid_i) begin
          median_d = median_i;
          tbl_d    = tbl_i;
          idx_d    = '0;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (median_q <= rd.code) begin
          if ((idx_q == '0) || (rd.code <= prev_q.code)) begin
            // Below the first point or a degenerate segment: upper distance
            dist_d  = {rd.inches, {FRAC_BITS{1'b0}}};
            state_d = ST_DONE;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.mdiff = median_q - prev_q.code;
            div_req_o.span  = rd.inches - prev_q.inches;
            div_req_o.den   = rd.code - prev_q.code;
            base_d  = prev_q.inches;
            state_d = ST_DIV;
          end
        end else if (idx_q == tbl_last(tbl_q)) begin
          // Beyond the last point: clamp to its distance
          dist_d  = {rd.inches, {FRAC_BITS{1'b0}}};
          state_d = ST_DONE;
        end else begin
          prev_d    = rd;
          idx_d     = idx_q + idx_t'(1);
          ram_raddr = tbl_addr(tbl_q, idx_q + idx_t'(1));
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          dist_d  = dist_t'({base_q, {FRAC_BITS{1'b0}}} + div_rsp_i.quot[DIST_W-1:0]);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_o.valid = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // Working registers of the current word
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    tbl_q    <= tbl_d;
    median_q <= median_d;
    prev_q   <= prev_d;
    base_q   <= base_d;
    dist_q   <= dist_d;
  end

endmodule

`default_nettype wire

// ===== src/ir_adc_median_to_distance.sv =====
// IR distance from three ADC samples by piecewise-linear calibration.
// in_i carries a table selector and three raw samples; out_o returns the
// Q.8 distance in inches and the median sample, one word per input word.
// Both channels use valid/ready; a word moves when both are high.
// After reset the block copies its three calibration tables into an internal
// table RAM, one entry a cycle for all 48 entries, and keeps in_i.ready low
// until that is done.
// Each word is then accepted, walks the table one breakpoint a cycle (up to
// 16, one RAM read each) and, when the median falls inside a segment, runs
// the bit-serial divider over its 25 quotient bits up to its completion pulse,
// then is handed off to the output register.
// Words are processed one at a time; a new word is taken as soon as the
// previous result sits in the output register.
// When the receiver stalls, the result waits in the output register and the
// block keeps working on the next word, then holds until the register frees.
`default_nettype none

module ir_adc_median_to_distance (
  input wire logic clk_i,
  input wire logic rst_ni,
  ird_in_if.sink   in_i,
  ird_out_if.source out_o
);
  import ird_pkg::*;

  logic     out_valid_q;
  dist_t    dist_q;
  adc_t     median_q;
  logic     out_free;
  adc_t     median;
  tbl_e     tbl;
  res_t     res;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Median and table choice of the incoming word
  assign median = med3(in_i.sample_a, in_i.sample_b, in_i.sample_c);
  assign tbl    = sel_to_tbl(in_i.sensor_sel);

  assign out_free = !out_valid_q || out_o.ready;

  ird_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .tbl_i      (tbl),
    .median_i   (median),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .res_o      (res),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  ird_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      dist_q   <= res.distance;
      median_q <= res.median;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.distance_q8 = dist_q;
  assign out_o.median_raw  = median_q;

endmodule

`default_nettype wire

// ===== tb/ird_distance_checker.sv =====
`timescale 1ns / 1ps

module ird_distance_checker
  import ird_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ird_in_if    in_w,
  ird_out_if   out_w,
  output int   err_count_o,
  output int   pending_o,
  output int   checked_o
);

  // Keep the log short when something goes badly wrong
  localparam int MAX_PRINT = 40;

  // Calibration breakpoints: ADC code and whole inches, per table
  localparam int PT_CODE [3][16] = '{
    '{205, 1533, 2397, 3025, 3353, 3409, 3537, 3580,
      3600, 3640, 3660, 3817, 0, 0, 0, 0},
    '{128, 243, 273, 349, 890, 1457, 1900, 2265,
      2513, 2745, 2890, 3000, 3125, 3200, 3265, 3717},
    '{190, 555, 2197, 2937, 3269, 3473, 3545, 3609,
      3656, 3700, 3720, 3792, 0, 0, 0, 0}
  };
  localparam int PT_INCH [3][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 18, 0, 0, 0, 0},
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 18},
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 18, 0, 0, 0, 0}
  };
  localparam int PT_COUNT [3] = '{12, 16, 12};

  typedef struct packed {
    dist_t distance;
    adc_t  median;
  } distance_word_t;

  distance_word_t exp_dist_q[$];
  distance_word_t want_w;
  adc_t           med;

  // Middle value of three samples
  function automatic adc_t middle_of(adc_t a, adc_t b, adc_t c);
    if ((a >= b && a <= c) || (a <= b && a >= c)) return a;
    if ((b >= a && b <= c) || (b <= a && b >= c)) return b;
    return c;
  endfunction

  // Map a selector onto its calibration table; the spare code falls back to center
  function automatic tbl_e table_of(sel_t sel);
    tbl_e t;
    case (sel)
      sel_t'(TBL_LEFT):  t = TBL_LEFT;
      sel_t'(TBL_RIGHT): t = TBL_RIGHT;
      default:           t = TBL_CENTER;
    endcase
    return t;
  endfunction

  // Piecewise-linear interpolation of a median through one table
  function automatic dist_t interp_distance(tbl_e t, adc_t m);
    int     ti;
    int     a0;
    int     a1;
    int     d0;
    int     d1;
    longint num;
    ti = int'(t);
    if (int'(m) <= PT_CODE[ti][0]) return dist_t'(PT_INCH[ti][0] << FRAC_BITS);
    for (int i = 1; i < PT_COUNT[ti]; i++) begin
      if (int'(m) <= PT_CODE[ti][i]) begin
        a0 = PT_CODE[ti][i-1];
        a1 = PT_CODE[ti][i];
        d0 = PT_INCH[ti][i-1];
        d1 = PT_INCH[ti][i];
        // degenerate segment gives its upper distance
        if (a1 <= a0) return dist_t'(d1 << FRAC_BITS);
        num = longint'(int'(m) - a0) * longint'((d1 - d0) << FRAC_BITS);
        return dist_t'(longint'(d0 << FRAC_BITS) + num / longint'(a1 - a0));
      end
    end
    // above the last breakpoint: no wall in range
    return dist_t'(PT_INCH[ti][PT_COUNT[ti]-1] << FRAC_BITS);
  endfunction

  // Print a line per mismatch, up to MAX_PRINT of them, and count every mismatch
  task automatic report_mismatch(string what, int got, int want);
    if (err_count_o < MAX_PRINT)
      $display("MISMATCH at %0t: %s: got %0d, want %0d", $time, what, got, want);
    err_count_o++;
  endtask

  initial begin
    err_count_o = 0;
    checked_o   = 0;
    pending_o   = 0;
  end

  // Predict on every accepted input word, compare on every accepted output word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_dist_q.delete();
      pending_o <= 0;
    end else begin
      if (in_w.valid && in_w.ready) begin
        med = middle_of(in_w.sample_a, in_w.sample_b, in_w.sample_c);
        want_w.median   = med;
        want_w.distance = interp_distance(table_of(in_w.sensor_sel), med);
        exp_dist_q.push_back(want_w);
      end
      if (out_w.valid && out_w.ready) begin
        if (exp_dist_q.size() == 0) begin
          report_mismatch("result word with nothing expected",
                          int'(out_w.distance_q8), -1);
        end else begin
          want_w = exp_dist_q.pop_front();
          checked_o++;
          if (out_w.distance_q8 !== want_w.distance)
            report_mismatch("distance_q8", int'(out_w.distance_q8),
                            int'(want_w.distance));
          if (out_w.median_raw !== want_w.median)
            report_mismatch("median_raw", int'(out_w.median_raw),
                            int'(want_w.median));
        end
      end
      pending_o <= exp_dist_q.size();
    end
  end

endmodule

// ===== tb/tb_ir_adc_median_to_distance.sv =====
`timescale 1ns / 1ps

module tb_ir_adc_median_to_distance;
  import ird_pkg::*;

  localparam int   LIMIT_CYCLES = 800000;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   HOLD_WORDS   = 12;
  localparam int   DRAIN_CYCLES = 100;
  localparam int   RAND_A_WORDS = 600;
  localparam int   RAND_B_WORDS = 300;
  localparam int   QUIET_WORDS  = 140;
  localparam sel_t SEL_SPARE    = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ird_in_if  in_w ();
  ird_out_if out_w ();

  int err_count;
  int pending_cnt;
  int checked_cnt;
  int cycle_cnt   = 0;
  int words_sent  = 0;
  int sel_hits [4] = '{0, 0, 0, 0};
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  bit hold_req    = 1'b0;

  ir_adc_median_to_distance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  ird_distance_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w),
    .out_w       (out_w),
    .err_count_o (err_count),
    .pending_o   (pending_cnt),
    .checked_o   (checked_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Breakpoint code and count of the table a selector picks
  function automatic int bp_code(sel_t s, int idx);
    case (s)
      sel_t'(TBL_LEFT):  return int'(CAL_LEFT[idx].code);
      sel_t'(TBL_RIGHT): return int'(CAL_RIGHT[idx].code);
      default:           return int'(CAL_CENTER[idx].code);
    endcase
  endfunction

  function automatic int bp_count(sel_t s);
    if (s == sel_t'(TBL_LEFT) || s == sel_t'(TBL_RIGHT)) return 12;
    return MAX_POINTS;
  endfunction

  // Offer one word, with an optional idle burst ahead of it
  task automatic push_word(sel_t s, adc_t a, adc_t b, adc_t c);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.sensor_sel <= s;
    in_w.sample_a   <= a;
    in_w.sample_b   <= b;
    in_w.sample_c   <= c;
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
    sel_hits[s]++;
  endtask

  // Build three samples around a chosen median, median in a random slot
  task automatic push_median(sel_t s, int m);
    adc_t mm;
    adc_t lo;
    adc_t hi;
    if (m < 0) m = 0;
    if (m > 4095) m = 4095;
    mm = adc_t'(m);
    lo = adc_t'($urandom_range(0, m));
    hi = adc_t'($urandom_range(m, 4095));
    case ($urandom_range(0, 5))
      0:       push_word(s, mm, lo, hi);
      1:       push_word(s, mm, hi, lo);
      2:       push_word(s, lo, mm, hi);
      3:       push_word(s, hi, mm, lo);
      4:       push_word(s, lo, hi, mm);
      default: push_word(s, hi, lo, mm);
    endcase
  endtask

  // Favor medians near breakpoints and inside the table span
  function automatic int pick_median(sel_t s);
    int n;
    int r;
    n = bp_count(s);
    r = $urandom_range(0, 9);
    if (r < 4) return bp_code(s, $urandom_range(0, n - 1)) + $urandom_range(0, 6) - 3;
    if (r < 8) return $urandom_range(bp_code(s, 0) - 60, bp_code(s, n - 1) + 60);
    return $urandom_range(0, 4095);
  endfunction

  task automatic push_random;
    sel_t s;
    s = sel_t'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0)
      push_word(s, adc_t'($urandom), adc_t'($urandom), adc_t'($urandom));
    else
      push_median(s, pick_median(s));
  endtask

  // Hold off the source until every expected word is back
  task automatic drain_pause;
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0 || hold_req) @(posedge clk_i);
  endtask

  // Watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("TIMEOUT after %0d cycles, %0d words still expected", cycle_cnt, pending_cnt);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random ready bursts, one long hold-off on request
  initial begin
    out_w.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_w.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 2) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_w.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int n;
    int first;
    int last;
    int mid;
    in_w.valid      <= 1'b0;
    in_w.sensor_sel <= '0;
    in_w.sample_a   <= '0;
    in_w.sample_b   <= '0;
    in_w.sample_c   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and sample orderings
    push_word(sel_t'(TBL_LEFT), 12'd0, 12'd0, 12'd0);
    push_word(sel_t'(TBL_CENTER), 12'd4095, 12'd4095, 12'd4095);
    push_word(sel_t'(TBL_RIGHT), 12'd0, 12'd4095, 12'd0);
    push_word(SEL_SPARE, 12'd4095, 12'd0, 12'd4095);
    push_word(sel_t'(TBL_CENTER), 12'd2000, 12'd100, 12'd3000);
    push_word(sel_t'(TBL_CENTER), 12'd100, 12'd2000, 12'd3000);
    push_word(sel_t'(TBL_CENTER), 12'd100, 12'd3000, 12'd2000);

    // Per table: on and just past the first and last breakpoints, on an inner
    // breakpoint, and halfway along a segment
    for (int t = 0; t < 3; t++) begin
      n     = bp_count(sel_t'(t));
      first = bp_code(sel_t'(t), 0);
      last  = bp_code(sel_t'(t), n - 1);
      mid   = bp_code(sel_t'(t), 3);
      push_word(sel_t'(t), 12'd0, adc_t'(first), 12'd4095);
      push_word(sel_t'(t), adc_t'(first + 1), 12'd4095, 12'd0);
      push_word(sel_t'(t), adc_t'(last), adc_t'(last), adc_t'(last));
      push_word(sel_t'(t), 12'd4095, adc_t'(last + 1), adc_t'(last + 1));
      push_word(sel_t'(t), adc_t'(mid), 12'd0, 12'd4095);
      push_median(sel_t'(t), (bp_code(sel_t'(t), 4) + bp_code(sel_t'(t), 5)) / 2);
    end
    push_word(SEL_SPARE, 12'd243, 12'd243, 12'd4095);

    // Random words with idling on both sides
    for (int i = 0; i < RAND_A_WORDS; i++) push_random();

    // Long output stall while the source keeps offering, then a drain pause
    hold_req = 1'b1;
    for (int i = 0; i < HOLD_WORDS; i++) push_random();
    drain_pause();

    for (int i = 0; i < RAND_B_WORDS; i++) push_random();

    // Back-to-back tail with no idling anywhere
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int i = 0; i < QUIET_WORDS; i++) push_random();
    in_w.valid <= 1'b0;

    // Wait for the last results, then watch for strays
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d words (left %0d, center %0d, right %0d, spare select %0d), %0d checked",
             words_sent, sel_hits[0], sel_hits[1], sel_hits[2], sel_hits[3], checked_cnt);
    $display("including breakpoint edges, out-of-range medians, a long output stall and a drain pause");
    if (err_count == 0 && pending_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ird_pkg.sv
src/ird_if.sv
src/ird_ram.sv
src/ird_div.sv
src/ird_ctrl.sv
src/ir_adc_median_to_distance.sv
tb/ird_distance_checker.sv
tb/tb_ir_adc_median_to_distance.sv
